[design/fsa_pkg.sv]
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants for face_scatter_accumulate
// Item and result words, queued memory operations, codes and cell checks.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int NUM_CELLS   = 1024;
  localparam int ADDR_W      = $clog2(NUM_CELLS);
  localparam int IDX_W       = 10;
  localparam int CMP_W       = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_SCATTER = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // scatter modes
  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_SUB      = 2'd1;
  localparam logic [1:0] MODE_ABS_SWAP = 2'd2;
  localparam logic [1:0] MODE_SUB_SWAP = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   cell_index;
    logic signed [31:0] cell_value;
    logic [IDX_W-1:0]   lower_cell;
    logic [IDX_W-1:0]   upper_cell;
    logic signed [31:0] lower_coeff;
    logic signed [31:0] upper_coeff;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               overflow_seen;
  } out_result_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_ADD,
    OP_READ
  } op_code_t;

  // one memory operation; data is a store value or a 33-bit delta
  typedef struct packed {
    op_code_t           code;
    logic               ok;
    logic [ADDR_W-1:0]  addr;
    logic signed [32:0] data;
  } op_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } back_state_t;

  function automatic logic cell_ok(input logic [IDX_W-1:0] idx);
    return CMP_W'(idx) < CMP_W'(NUM_CELLS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] idx);
    return ADDR_W'(idx);
  endfunction

endpackage

[design/fsa_queue.sv]
// ----------------------------------------------------------------------------
// fsa_queue: short operation queue
// Decouples the classifying front from the memory back end.
// ----------------------------------------------------------------------------
module fsa_queue import fsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic full,
  output logic empty
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");

endmodule

[design/fsa_front.sv]
// ----------------------------------------------------------------------------
// fsa_front: item intake and classification
// Turns one item into zero, one or two memory operations and feeds the queue.
// ----------------------------------------------------------------------------
module fsa_front import fsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  logic       start,
  input  in_item_t   item,
  input  logic [1:0] scatter_mode,
  input  logic       q_full,
  output logic       ready,
  output logic       push,
  output op_t        push_op
);

  op_t        op0;
  op_t        op1;
  logic [1:0] stage_cnt;

  op_t        new0;
  op_t        new1;
  logic [1:0] new_cnt;
  logic       accept;

  logic signed [32:0] lo;
  logic signed [32:0] up;
  logic signed [32:0] lo_neg;
  logic signed [32:0] up_neg;
  logic [ADDR_W-1:0]  lc_addr;
  logic [ADDR_W-1:0]  uc_addr;
  logic               lc_ok;
  logic               uc_ok;

  assign push    = (stage_cnt != 2'd0) && !q_full;
  assign push_op = op0;
  assign ready   = enable && ((stage_cnt == 2'd0) || ((stage_cnt == 2'd1) && !q_full));
  assign accept  = start && ready;

  always_comb begin
    lo      = 33'(item.lower_coeff);
    up      = 33'(item.upper_coeff);
    lo_neg  = -lo;
    up_neg  = -up;
    lc_addr = cell_addr(item.lower_cell);
    uc_addr = cell_addr(item.upper_cell);
    lc_ok   = cell_ok(item.lower_cell);
    uc_ok   = cell_ok(item.upper_cell);

    new0    = '{code: OP_READ, ok: cell_ok(item.cell_index),
                addr: cell_addr(item.cell_index), data: 33'(item.cell_value)};
    new1    = new0;
    new_cnt = 2'd0;

    unique case (item.kind)
      KIND_LOAD: begin
        new0.code = OP_WRITE;
        new_cnt   = 2'd1;
      end
      KIND_SCATTER: begin
        new_cnt = 2'd2;
        unique case (scatter_mode)
          MODE_ADD: begin
            new0 = '{code: OP_ADD, ok: lc_ok, addr: lc_addr, data: lo};
            new1 = '{code: OP_ADD, ok: uc_ok, addr: uc_addr, data: up};
          end
          MODE_SUB: begin
            new0 = '{code: OP_ADD, ok: lc_ok, addr: lc_addr, data: lo_neg};
            new1 = '{code: OP_ADD, ok: uc_ok, addr: uc_addr, data: up_neg};
          end
          MODE_ABS_SWAP: begin
            new0 = '{code: OP_ADD, ok: uc_ok, addr: uc_addr, data: lo[32] ? lo_neg : lo};
            new1 = '{code: OP_ADD, ok: lc_ok, addr: lc_addr, data: up[32] ? up_neg : up};
          end
          default: begin
            new0 = '{code: OP_ADD, ok: uc_ok, addr: uc_addr, data: lo_neg};
            new1 = '{code: OP_ADD, ok: lc_ok, addr: lc_addr, data: up_neg};
          end
        endcase
      end
      KIND_READ: begin
        new_cnt = 2'd1;
      end
      default: begin
        new_cnt = 2'd0;   // unused kind: dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op0 <= new0;
      op1 <= new1;
    end else if (push) begin
      op0 <= op1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_cnt <= 2'd0;
    end else if (accept) begin
      stage_cnt <= new_cnt;
    end else if (push) begin
      stage_cnt <= stage_cnt - 2'd1;
    end
  end

  a_accept_empties: assert property (@(posedge clk) disable iff (rst)
      (accept && (stage_cnt == 2'd1)) |-> push)
    else $error("front overwrote an operation not yet queued");

endmodule

[design/fsa_back.sv]
// ----------------------------------------------------------------------------
// fsa_back: accumulator memory and read-modify-write pipeline
// Clears the array after reset, then runs one queued operation per cycle.
// ----------------------------------------------------------------------------
module fsa_back import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  op_t         head,
  input  logic        q_empty,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output out_result_t result
);

  logic signed [31:0] mem [NUM_CELLS];
  logic signed [31:0] rd_data;

  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;

  logic s1_valid;
  op_t  s1_op;

  // one-deep forward of the previous write
  logic               last_we;
  logic [ADDR_W-1:0]  last_addr;
  logic signed [31:0] last_wdata;

  logic sticky;

  logic signed [31:0] acc;
  logic signed [33:0] sum;
  logic               ovf;
  logic signed [31:0] wdata;
  logic               we;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic signed [31:0] mem_wdata;

  assign clr_last = (clr_addr == ADDR_W'(NUM_CELLS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_last) state_next = BK_RUN;
      BK_RUN:   state_next = BK_RUN;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state == BK_CLEAR);
    pop      = (state == BK_RUN) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // stage 2: merge, saturate, write back
  always_comb begin
    acc = (last_we && (last_addr == s1_op.addr)) ? last_wdata : rd_data;
    sum = 34'(acc) + 34'(s1_op.data);
    ovf = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);
    if (s1_op.code == OP_WRITE) begin
      wdata = s1_op.data[31:0];
    end else if (ovf) begin
      wdata = sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      wdata = sum[31:0];
    end
    we = s1_valid && s1_op.ok && ((s1_op.code == OP_WRITE) || (s1_op.code == OP_ADD));

    mem_we    = we || clearing;
    mem_waddr = clearing ? clr_addr : s1_op.addr;
    mem_wdata = clearing ? 32'sd0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[head.addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op <= head;
    end
    last_addr  <= s1_op.addr;
    last_wdata <= wdata;
    result.read_value    <= s1_op.ok ? acc : 32'sd0;
    result.overflow_seen <= sticky;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      last_we  <= 1'b0;
      sticky   <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop;
      last_we  <= we;
      done     <= s1_valid && (s1_op.code == OP_READ);
      if (we && (s1_op.code == OP_ADD) && ovf) begin
        sticky <= 1'b1;
      end
    end
  end

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst) sticky |=> sticky)
    else $error("overflow flag dropped");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("operation taken during clear sweep");

endmodule

[design/face_scatter_accumulate.sv]
// ----------------------------------------------------------------------------
// face_scatter_accumulate: per-cell Q16.16 accumulator for face sparse matrices
// Top level: configuration register, intake front, queue and memory back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the word is taken at a clock
//   edge where start is high and busy is low. kind selects load, scatter
//   (two saturating updates per face) or read; kind 3 is dropped.
//   Config channel: cfg_data carries scatter_mode, written when cfg_valid
//   and cfg_ready are high. cfg_ready is always high; write only while idle.
//   Result channel: a read item returns one word on result, marked by done
//   for exactly one cycle. The receiver cannot stall; results never wait.
// Timing:
//   done and result are registered together. An accepted item passes the front
//   operation register, a queue slot and the back end's stage-1 register. A
//   scatter issues two memory operations, one per cycle while the queue has
//   room; load and read issue one. The back end retires one read-modify-write
//   per cycle: memory with split read/write ports and a one-deep write forward.
// Reset:
//   rst (synchronous) clears the flag and mode, then a sweep writes zero
//   to all NUM_CELLS entries, one per cycle; busy stays high during the sweep.
//   Config writes are taken throughout.
// ----------------------------------------------------------------------------
module face_scatter_accumulate import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output out_result_t result
);

  logic [1:0] scatter_mode;

  logic front_ready;
  logic push;
  op_t  push_op;
  logic pop;
  op_t  head;
  logic q_full;
  logic q_empty;
  logic clearing;

  assign cfg_ready = 1'b1;
  assign busy      = !front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scatter_mode <= MODE_ADD;
    end else if (cfg_valid && cfg_ready) begin
      scatter_mode <= cfg_data;
    end
  end

  // front: classify items into memory operations
  fsa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .enable       (!clearing),
    .start        (start),
    .item         (item),
    .scatter_mode (scatter_mode),
    .q_full       (q_full),
    .ready        (front_ready),
    .push         (push),
    .push_op      (push_op)
  );

  fsa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // back: accumulator array, saturation, read results
  fsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
      clearing |-> busy)
    else $error("item taken during clear sweep");

endmodule
